>>> rtl/bdcc_pkg.sv
// Package for the button debounce and click counter.
// Holds event codes, register indexes and the structs shared by the core and top level.
// No dependencies.
`default_nettype none

package bdcc_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2
  } event_code_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SWITCH_MODE   = 2'd0,
    REG_DEFAULT_LEVEL = 2'd1,
    REG_DEBOUNCE_MS   = 2'd2,
    REG_REPEAT_MS     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        switch_mode;
    logic        default_level;
    logic [15:0] debounce_ms;
    logic [15:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    event_code_e event_code;
    logic [15:0] click_count;
    logic [31:0] press_length;
    logic        is_pressed;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/button_debounce_click_counter.sv
// Button debouncer with click counting: one pin sample word in, one result word out.
// The result word is registered and valid in the cycle after its input word is accepted.
// Throughput: 1 word per cycle unless stalled; output register refills while taken.
// Reset: asynchronous active low; all but res_q return to power-up values at once.
// Depends on bdcc_pkg and bdcc_core.
`default_nettype none

module button_debounce_click_counter
  import bdcc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,  // [0] pin_level
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [55:0]         m_axis_tdata_o,  // [15:0] click_count,
                                                    // [47:16] press_length, [48] is_pressed
  output      logic [1:0]          m_axis_tuser_o   // [1:0] event_code
);

  cfg_t    cfg_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    in_fire;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.switch_mode   <= 1'b0;
      cfg_q.default_level <= 1'b1;
      cfg_q.debounce_ms   <= 16'd50;
      cfg_q.repeat_ms     <= 16'd500;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_SWITCH_MODE:   cfg_q.switch_mode   <= cfg_data_i[0];
        REG_DEFAULT_LEVEL: cfg_q.default_level <= cfg_data_i[0];
        REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data_i;
        REG_REPEAT_MS:     cfg_q.repeat_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bdcc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .pin_i  (s_axis_tdata_i[0]),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q.is_pressed, res_q.press_length, res_q.click_count};
  assign m_axis_tuser_o  = res_q.event_code;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result word is stalled");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid_o)
    else $error("accepted word produced no result word");

  a_event_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("illegal event code");
`endif

endmodule

`default_nettype wire

>>> rtl/bdcc_core.sv
// Debounce and click state for the button debounce and click counter.
// Holds the state registers and computes the next state and result of one tick.
// Depends on bdcc_pkg.
`default_nettype none

module bdcc_core
  import bdcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire logic    pin_i,
  input  wire cfg_t    cfg_i,
  output      result_t res_o
);

  logic        stable_q, stable_d;
  logic        settling_q, settling_d;
  logic [15:0] settle_q, settle_d;
  logic [31:0] since_q, since_d;
  logic [31:0] held_q, held_d;
  logic [15:0] series_q, series_d;
  logic        pending_q, pending_d;
  logic        restart_q, restart_d;
  logic        check;
  logic [15:0] settle_dec;
  event_code_e ev;

  always_comb begin
    stable_d   = stable_q;
    settling_d = settling_q;
    settle_d   = settle_q;
    held_d     = held_q;
    series_d   = series_q;
    pending_d  = pending_q;
    restart_d  = restart_q;
    check      = 1'b0;
    ev         = EV_NONE;
    settle_dec = settle_q - 16'd1;
    since_d    = (since_q != 32'hFFFF_FFFF) ? since_q + 32'd1 : since_q;

    if (settling_q) begin
      settle_d = settle_dec;
      if (settle_dec == 16'd0) begin
        settling_d = 1'b0;
        check      = 1'b1;
      end
    end else if (pin_i != stable_q) begin
      if (cfg_i.debounce_ms == 16'd0) begin
        check = 1'b1;
      end else begin
        settling_d = 1'b1;
        settle_d   = cfg_i.debounce_ms;
      end
    end

    if (check && (pin_i != stable_q)) begin
      stable_d = ~stable_q;
      if (cfg_i.switch_mode) begin
        ev = (stable_d != cfg_i.default_level) ? EV_PRESSED : EV_RELEASED;
      end else if (stable_d == cfg_i.default_level) begin
        held_d    = since_d;
        pending_d = 1'b1;
      end else begin
        ev      = EV_PRESSED;
        since_d = 32'd0;
        held_d  = 32'd0;
        if (restart_q) begin
          series_d  = 16'd1;
          restart_d = 1'b0;
        end else if (series_q != 16'hFFFF) begin
          series_d = series_q + 16'd1;
        end
        pending_d = 1'b0;
      end
    end

    if (pending_d && (since_d > {16'd0, cfg_i.repeat_ms})) begin
      pending_d = 1'b0;
      restart_d = 1'b1;
      ev        = EV_RELEASED;
    end

    res_o.event_code   = ev;
    res_o.click_count  = series_d;
    res_o.press_length = held_d;
    res_o.is_pressed   = stable_d != cfg_i.default_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b1;
      settling_q <= 1'b0;
      settle_q   <= 16'd0;
      since_q    <= 32'd0;
      held_q     <= 32'd0;
      series_q   <= 16'd0;
      pending_q  <= 1'b0;
      restart_q  <= 1'b0;
    end else if (step_i) begin
      stable_q   <= stable_d;
      settling_q <= settling_d;
      settle_q   <= settle_d;
      since_q    <= since_d;
      held_q     <= held_d;
      series_q   <= series_d;
      pending_q  <= pending_d;
      restart_q  <= restart_d;
    end
  end

`ifndef SYNTHESIS
  a_settle_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settling_q |-> (settle_q != 16'd0))
    else $error("settling wait with zero ticks left");

  a_press_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !cfg_i.switch_mode && (ev == EV_PRESSED)) |=> (series_q != 16'd0))
    else $error("button press left click count at zero");

  a_press_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !cfg_i.switch_mode && (ev == EV_PRESSED)) |=> (since_q == 32'd0))
    else $error("button press did not restart the press timer");
`endif

endmodule

`default_nettype wire
